// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, quiet while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an implication holds on every rising edge, quiet while in reset.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/mri_pkg.sv
`default_nettype none
package mri_pkg;

  // Request field widths
  localparam int CMD_W     = 3;
  localparam int NEURON_W  = 7;
  localparam int COLUMN_W  = 10;
  localparam int VALUE_W   = 16;
  localparam int CLASS_W   = 4;
  localparam int SCORE_W   = 48;
  localparam int PIXEL_W   = 8;
  localparam int HVAL_W    = 15;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int INCNT_W    = 11;
  localparam int HIDCNT_W   = 8;
  localparam int CLSCNT_W   = 5;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT  = 2'd2;

  localparam logic [INCNT_W-1:0]  INPUT_COUNT_RST  = 11'd784;
  localparam logic [HIDCNT_W-1:0] HIDDEN_COUNT_RST = 8'd100;
  localparam logic [CLSCNT_W-1:0] CLASS_COUNT_RST  = 5'd10;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_HID_WEIGHT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HID_BIAS   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLS_WEIGHT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLS_BIAS   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PIXEL      = 3'd4;

  typedef logic signed [VALUE_W-1:0] coef_t;
  typedef logic signed [SCORE_W-1:0] score_t;

endpackage
`default_nettype wire

// File: hdl/mri_if.sv
`default_nettype none
// Request channel: one load or pixel item
interface mri_req_if;
  import mri_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [NEURON_W-1:0] neuron;
  logic [COLUMN_W-1:0] column;
  coef_t               value;
  logic                last;
  modport source (output valid, cmd, neuron, column, value, last, input ready);
  modport sink (input valid, cmd, neuron, column, value, last, output ready);
endinterface

// Result channel: winning class and its score
interface mri_res_if;
  import mri_pkg::*;
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] predicted_class;
  score_t             best_score;
  modport source (output valid, predicted_class, best_score, input ready);
  modport sink (input valid, predicted_class, best_score, output ready);
endinterface
`default_nettype wire

// File: hdl/mlp_relu_inference_argmax_unit.sv
// Load requests (weights, biases, pixels) are taken one per cycle while idle.
// A last pixel starts inference: the hidden layer and then the class layer run
// on the one shared multiply-accumulate unit, each followed by a pipeline
// drain, and a hand-off state loads the result register; no request is taken
// meanwhile, nor while that state waits for an earlier result to be taken.
// Reset (synchronous, rst high) clears control and restores the counts.
`default_nettype none
`include "assert_macros.svh"
module mlp_relu_inference_argmax_unit #(
  parameter int MAX_INPUTS  = 1024,
  parameter int MAX_HIDDEN  = 128,
  parameter int MAX_CLASSES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mri_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mri_pkg::CFG_DATA_W-1:0] cfg_data,
  mri_req_if.sink                       req,
  mri_res_if.source                     res
);
  import mri_pkg::*;

  localparam int PIX_AW   = $clog2(MAX_INPUTS);
  localparam int HID_AW   = $clog2(MAX_HIDDEN);
  localparam int CLS_AW   = $clog2(MAX_CLASSES);
  localparam int HW_DEPTH = MAX_HIDDEN * MAX_INPUTS;
  localparam int HW_AW    = $clog2(HW_DEPTH);
  localparam int CW_DEPTH = MAX_CLASSES * MAX_HIDDEN;
  localparam int CW_AW    = $clog2(CW_DEPTH);
  localparam int K_MAX    = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
  localparam int K_W      = $clog2(K_MAX);
  localparam int J_MAX    = (MAX_HIDDEN > MAX_CLASSES) ? MAX_HIDDEN : MAX_CLASSES;
  localparam int J_W      = $clog2(J_MAX);
  localparam int PROD_W   = VALUE_W + 17;
  localparam int ACC_MIN  = PROD_W + K_W + 2;
  localparam int ACC_W    = (ACC_MIN > SCORE_W + 1) ? ACC_MIN : SCORE_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_HRUN, S_HDRAIN, S_CRUN, S_CDRAIN, S_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [INCNT_W-1:0]  input_count;
  logic [HIDCNT_W-1:0] hidden_count;
  logic [CLSCNT_W-1:0] class_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count  <= INPUT_COUNT_RST;
      hidden_count <= HIDDEN_COUNT_RST;
      class_count  <= CLASS_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INPUT_COUNT:  input_count  <= cfg_data[INCNT_W-1:0];
        REG_HIDDEN_COUNT: hidden_count <= cfg_data[HIDCNT_W-1:0];
        REG_CLASS_COUNT:  class_count  <= cfg_data[CLSCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the counts and form last indexes
  logic [K_W-1:0] in_klim, hid_klim;
  logic [J_W-1:0] hid_jlim, cls_jlim;

  always_comb begin
    int n_in, n_hid, n_cls;
    n_in  = int'(input_count);
    n_hid = int'(hidden_count);
    n_cls = int'(class_count);
    if (n_in < 1) n_in = 1;
    if (n_in > MAX_INPUTS) n_in = MAX_INPUTS;
    if (n_hid < 1) n_hid = 1;
    if (n_hid > MAX_HIDDEN) n_hid = MAX_HIDDEN;
    if (n_cls < 1) n_cls = 1;
    if (n_cls > MAX_CLASSES) n_cls = MAX_CLASSES;
    in_klim  = K_W'(n_in - 1);
    hid_klim = K_W'(n_hid - 1);
    hid_jlim = J_W'(n_hid - 1);
    cls_jlim = J_W'(n_cls - 1);
  end

  // Request decode
  logic accept, neuron_hid_ok, neuron_cls_ok, col_in_ok, col_hid_ok;
  assign accept        = req.valid && req.ready;
  assign neuron_hid_ok = int'(req.neuron) < MAX_HIDDEN;
  assign neuron_cls_ok = int'(req.neuron) < MAX_CLASSES;
  assign col_in_ok     = int'(req.column) < MAX_INPUTS;
  assign col_hid_ok    = int'(req.column) < MAX_HIDDEN;

  logic hw_we, hb_we, cw_we, cb_we, px_we;
  assign hw_we = accept && req.cmd == CMD_HID_WEIGHT && neuron_hid_ok && col_in_ok;
  assign hb_we = accept && req.cmd == CMD_HID_BIAS && neuron_hid_ok;
  assign cw_we = accept && req.cmd == CMD_CLS_WEIGHT && neuron_cls_ok && col_hid_ok;
  assign cb_we = accept && req.cmd == CMD_CLS_BIAS && neuron_cls_ok;
  assign px_we = accept && req.cmd == CMD_PIXEL && col_in_ok;

  logic start;
  assign start = accept && req.cmd == CMD_PIXEL && req.last;

  // Sequencer counters: j picks the neuron or class, k the term
  logic [J_W-1:0] j;
  logic [K_W-1:0] k;
  logic           issue, issue_cls;
  assign issue     = (state == S_HRUN) || (state == S_CRUN);
  assign issue_cls = (state == S_CRUN);

  logic [K_W-1:0] klim;
  logic [J_W-1:0] jlim;
  assign klim = issue_cls ? hid_klim : in_klim;
  assign jlim = issue_cls ? cls_jlim : hid_jlim;

  // Memories
  coef_t             hw_mem [HW_DEPTH];
  coef_t             hb_mem [MAX_HIDDEN];
  coef_t             cw_mem [CW_DEPTH];
  coef_t             cb_mem [MAX_CLASSES];
  logic [PIXEL_W-1:0] px_mem [MAX_INPUTS];
  logic [HVAL_W-1:0]  hv_mem [MAX_HIDDEN];

  coef_t              hw_q, hb_q, cw_q, cb_q;
  logic [PIXEL_W-1:0] px_q;
  logic [HVAL_W-1:0]  hv_q;

  logic              hv_we;
  logic [J_W-1:0]    s3_j;
  logic [HVAL_W-1:0] hval;

  always_ff @(posedge clk) begin
    if (hw_we) hw_mem[HW_AW'(int'(req.neuron) * MAX_INPUTS + int'(req.column))] <= req.value;
    hw_q <= hw_mem[HW_AW'(int'(j) * MAX_INPUTS + int'(k))];
  end

  always_ff @(posedge clk) begin
    if (hb_we) hb_mem[HID_AW'(req.neuron)] <= req.value;
    hb_q <= hb_mem[HID_AW'(j)];
  end

  always_ff @(posedge clk) begin
    if (cw_we) cw_mem[CW_AW'(int'(req.neuron) * MAX_HIDDEN + int'(req.column))] <= req.value;
    cw_q <= cw_mem[CW_AW'(int'(j) * MAX_HIDDEN + int'(k))];
  end

  always_ff @(posedge clk) begin
    if (cb_we) cb_mem[CLS_AW'(req.neuron)] <= req.value;
    cb_q <= cb_mem[CLS_AW'(j)];
  end

  always_ff @(posedge clk) begin
    if (px_we) px_mem[PIX_AW'(req.column)] <= req.value[PIXEL_W-1:0];
    px_q <= px_mem[PIX_AW'(k)];
  end

  always_ff @(posedge clk) begin
    if (hv_we) hv_mem[HID_AW'(s3_j)] <= hval;
    hv_q <= hv_mem[HID_AW'(k)];
  end

  // Multiply-accumulate pipeline: read, multiply, accumulate, finish
  logic           s1_valid, s1_first, s1_end, s1_cls;
  logic [J_W-1:0] s1_j;
  logic           s2_valid, s2_first, s2_end, s2_cls;
  logic [J_W-1:0] s2_j;
  logic           s3_valid, s3_cls;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  bias_r, acc;

  coef_t            mul_a;
  logic [VALUE_W-1:0] mul_b;
  assign mul_a = s1_cls ? cw_q : hw_q;
  assign mul_b = s1_cls ? VALUE_W'(hv_q) : VALUE_W'(px_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && s2_end;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= (k == '0);
    s1_end   <= (k == klim);
    s1_cls   <= issue_cls;
    s1_j     <= j;
    s2_first <= s1_first;
    s2_end   <= s1_end;
    s2_cls   <= s1_cls;
    s2_j     <= s1_j;
    prod     <= PROD_W'(mul_a * $signed({1'b0, mul_b}));
    bias_r   <= s1_cls ? (ACC_W'(cb_q) <<< 12) : (ACC_W'(hb_q) <<< 8);
    if (s2_valid) acc <= (s2_first ? bias_r : acc) + ACC_W'(prod);
    s3_cls   <= s2_cls;
    s3_j     <= s2_j;
  end

  // Finish a hidden neuron: ReLU, drop 8 fraction bits, saturate
  logic signed [ACC_W-1:0] acc_sh;
  assign acc_sh = acc >>> 8;
  always_comb begin
    if (acc[ACC_W-1]) hval = '0;
    else if (acc_sh > ACC_W'(32767)) hval = '1;
    else hval = acc_sh[HVAL_W-1:0];
  end
  assign hv_we = s3_valid && !s3_cls;

  // Finish a class: saturate to the score width and keep the first maximum
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'({1'b0, {(SCORE_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

  score_t         score;
  score_t         best;
  logic [J_W-1:0] best_cls;

  always_comb begin
    if (acc > SMAX) score = SMAX[SCORE_W-1:0];
    else if (acc < SMIN) score = SMIN[SCORE_W-1:0];
    else score = acc[SCORE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (s3_valid && s3_cls && (s3_j == '0 || score > best)) begin
      best     <= score;
      best_cls <= s3_j;
    end
  end

  // Sequencer and result register
  logic               out_valid;
  logic [CLASS_W-1:0] out_class;
  score_t             out_score;
  logic               drained;
  assign drained = !s1_valid && !s2_valid && !s3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      j         <= '0;
      k         <= '0;
    end else begin
      // Load the result register, or drop it once taken
      if (state == S_DONE && (!out_valid || res.ready)) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          j <= '0;
          k <= '0;
          if (start) state <= S_HRUN;
        end
        S_HRUN, S_CRUN: begin
          if (k == klim) begin
            k <= '0;
            if (j == jlim) begin
              j     <= '0;
              state <= issue_cls ? S_CDRAIN : S_HDRAIN;
            end else begin
              j <= j + 1'b1;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        S_HDRAIN: if (drained) state <= S_CRUN;
        S_CDRAIN: if (drained) state <= S_DONE;
        S_DONE: begin
          if (!out_valid || res.ready) begin
            out_class <= CLASS_W'(best_cls);
            out_score <= best;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready           = (state == S_IDLE);
  assign res.valid           = out_valid;
  assign res.predicted_class = out_class;
  assign res.best_score      = out_score;

  // Checks
  `ASSERT_IMPLY(a_pipe_busy, s1_valid, state != S_IDLE, "MAC pipeline active while idle")
  `ASSERT_IMPLY(a_result_src, $rose(out_valid), $past(state == S_DONE), "result without inference")
  `ASSERT_IMPLY(a_drain_exit, state == S_HDRAIN && drained, ##1 state == S_CRUN, "hidden drain stuck")

endmodule
`default_nettype wire

// File: test/mri_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module mri_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mri_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mri_pkg::CFG_DATA_W-1:0] cfg_data,
  mri_req_if                             req,
  mri_res_if                             res,
  output int                             fail_count,
  output int                             pending
);
  import mri_pkg::*;

  localparam int N_IN  = 1024;
  localparam int N_HID = 128;
  localparam int N_CLS = 16;
  localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    score_t             score;
  } verdict_t;

  verdict_t verdict_q[$];

  coef_t              hid_weight [N_HID*N_IN];
  coef_t              hid_bias   [N_HID];
  coef_t              cls_weight [N_CLS*N_HID];
  coef_t              cls_bias   [N_CLS];
  logic [PIXEL_W-1:0] pixel      [N_IN];
  logic [HVAL_W-1:0]  hid_value  [N_HID];

  logic [INCNT_W-1:0]  in_cnt;
  logic [HIDCNT_W-1:0] hid_cnt;
  logic [CLSCNT_W-1:0] cls_cnt;

  function automatic int clamp_count(int v, int top);
    if (v < 1) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // Run both layers and pick the first class with the top score
  function automatic verdict_t classify();
    int       n_in;
    int       n_hid;
    int       n_cls;
    longint   acc;
    longint   top_score;
    int       top_cls;
    verdict_t v;
    n_in  = clamp_count(int'(in_cnt), N_IN);
    n_hid = clamp_count(int'(hid_cnt), N_HID);
    n_cls = clamp_count(int'(cls_cnt), N_CLS);
    top_score = 0;
    top_cls = 0;
    for (int j = 0; j < n_hid; j++) begin
      acc = longint'(hid_bias[j]) * 256;
      for (int i = 0; i < n_in; i++)
        acc += longint'(hid_weight[j*N_IN+i]) * longint'({1'b0, pixel[i]});
      if (acc < 0) acc = 0;
      acc = acc / 256;
      if (acc > 32767) acc = 32767;
      hid_value[j] = acc[HVAL_W-1:0];
    end
    for (int j = 0; j < n_cls; j++) begin
      acc = longint'(cls_bias[j]) * 4096;
      for (int i = 0; i < n_hid; i++)
        acc += longint'(cls_weight[j*N_HID+i]) * longint'({1'b0, hid_value[i]});
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      if (j == 0 || acc > top_score) begin
        top_score = acc;
        top_cls = j;
      end
    end
    v.cls = top_cls[CLASS_W-1:0];
    v.score = top_score[SCORE_W-1:0];
    return v;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      in_cnt = INPUT_COUNT_RST;
      hid_cnt = HIDDEN_COUNT_RST;
      cls_cnt = CLASS_COUNT_RST;
      verdict_q.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_INPUT_COUNT:  in_cnt = cfg_data[INCNT_W-1:0];
          REG_HIDDEN_COUNT: hid_cnt = cfg_data[HIDCNT_W-1:0];
          REG_CLASS_COUNT:  cls_cnt = cfg_data[CLSCNT_W-1:0];
          default: ;
        endcase
      end
      // Apply an accepted request to the stores
      if (req.valid && req.ready) begin
        case (req.cmd)
          CMD_HID_WEIGHT: hid_weight[int'(req.neuron)*N_IN+int'(req.column)] = req.value;
          CMD_HID_BIAS:   hid_bias[req.neuron] = req.value;
          CMD_CLS_WEIGHT: begin
            if (req.neuron < N_CLS && req.column < N_HID)
              cls_weight[int'(req.neuron)*N_HID+int'(req.column)] = req.value;
          end
          CMD_CLS_BIAS: begin
            if (req.neuron < N_CLS) cls_bias[req.neuron[3:0]] = req.value;
          end
          CMD_PIXEL: begin
            pixel[req.column] = req.value[PIXEL_W-1:0];
            if (req.last) verdict_q.push_back(classify());
          end
          default: ;
        endcase
      end
      // Compare a delivered result with the oldest prediction
      if (res.valid && res.ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result: class %0d score %0d",
                 res.predicted_class, res.best_score);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (res.predicted_class !== want.cls) begin
            $error("predicted_class: expected %0d, got %0d", want.cls, res.predicted_class);
            fail_count++;
          end
          if (res.best_score !== want.score) begin
            $error("best_score: expected %0d, got %0d", want.score, res.best_score);
            fail_count++;
          end
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule
`default_nettype wire

// File: test/tb_mlp_relu_inference_argmax_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_mlp_relu_inference_argmax_unit;
  import mri_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  bit                    no_idle;

  mri_req_if req_ch ();
  mri_res_if res_ch ();

  mlp_relu_inference_argmax_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  mri_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (req_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Safety net against a hung block
  initial begin
    #60_000_000;
    $display("mlp_relu_inference_argmax_unit regression: fail");
    $finish;
  end

  // Offer one request, idling first for a random number of cycles unless no_idle is set
  task automatic send_req(logic [CMD_W-1:0] cmd, int neuron, int column,
                          coef_t value, bit last);
    int gap;
    bit got;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.cmd    <= cmd;
    req_ch.neuron <= neuron[NEURON_W-1:0];
    req_ch.column <= column[COLUMN_W-1:0];
    req_ch.value  <= value;
    req_ch.last   <= last;
    do begin
      @(negedge clk);
      got = req_ch.ready;
      @(posedge clk);
    end while (!got);
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(int in_n, int hid_n, int cls_n);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_INPUT_COUNT;
    cfg_data <= in_n[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_HIDDEN_COUNT;
    cfg_data <= hid_n[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_CLASS_COUNT;
    cfg_data <= cls_n[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic coef_t pick_coef();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return coef_t'($urandom_range(0, 64)) - 16'sd32;
      default: return coef_t'($urandom);
    endcase
  endfunction

  function automatic int eff(int v, int top);
    return v < 1 ? 1 : (v > top ? top : v);
  endfunction

  // Fill every entry the next inference reads, then start it
  task automatic load_net(int ni, int nh, int nc);
    for (int j = 0; j < nh; j++) begin
      send_req(CMD_HID_BIAS, j, $urandom_range(0, 1023), pick_coef(),
               1'($urandom_range(0, 1)));
      for (int i = 0; i < ni; i++) send_req(CMD_HID_WEIGHT, j, i, pick_coef(), 1'b0);
    end
    for (int c = 0; c < nc; c++) begin
      send_req(CMD_CLS_BIAS, c, 0, pick_coef(), 1'b0);
      for (int h = 0; h < nh; h++) send_req(CMD_CLS_WEIGHT, c, h, pick_coef(), 1'b0);
    end
    for (int i = 0; i < ni; i++)
      send_req(CMD_PIXEL, 0, i, coef_t'($urandom), i == ni - 1);
  endtask

  // Random traffic: mostly in-range rewrites and pixels, some ignored requests
  task automatic run_traffic(int count, int ni, int nh, int nc);
    int r;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) drain();
      no_idle = (k % 60) < 12;
      r = $urandom_range(0, 99);
      if (r < 30)
        send_req(CMD_PIXEL, 0, $urandom_range(0, ni - 1), coef_t'($urandom),
                 $urandom_range(0, 3) == 0);
      else if (r < 40)
        send_req(CMD_PIXEL, $urandom_range(0, 127), $urandom_range(0, 1023),
                 coef_t'($urandom), 1'($urandom_range(0, 1)));
      else if (r < 60)
        send_req(CMD_HID_WEIGHT, $urandom_range(0, nh - 1), $urandom_range(0, ni - 1),
                 pick_coef(), 1'b0);
      else if (r < 65)
        send_req(CMD_HID_WEIGHT, $urandom_range(0, 127), $urandom_range(0, 1023),
                 pick_coef(), 1'($urandom_range(0, 1)));
      else if (r < 70)
        send_req(CMD_HID_BIAS, $urandom_range(0, 127), 0, pick_coef(), 1'b0);
      else if (r < 82)
        send_req(CMD_CLS_WEIGHT, $urandom_range(0, nc - 1), $urandom_range(0, nh - 1),
                 pick_coef(), 1'b0);
      else if (r < 87)
        send_req(CMD_CLS_BIAS, $urandom_range(0, nc - 1), 0, pick_coef(), 1'b0);
      else if (r < 93)
        send_req($urandom_range(0, 1) ? CMD_CLS_WEIGHT : CMD_CLS_BIAS,
                 $urandom_range(16, 127), $urandom_range(0, 1023), pick_coef(),
                 1'($urandom_range(0, 1)));
      else if (r < 96)
        send_req(CMD_CLS_WEIGHT, $urandom_range(0, 15), $urandom_range(128, 1023),
                 pick_coef(), 1'b0);
      else
        send_req(CMD_PIXEL + 3'($urandom_range(1, 3)), $urandom_range(0, 127),
                 $urandom_range(0, 1023), coef_t'($urandom), 1'($urandom_range(0, 1)));
    end
    no_idle = 1'b0;
  endtask

  // Result side: random stalls, one long hold-off while requests keep coming
  initial begin
    int wait_n;
    int got_n;
    bit got;
    got_n = 0;
    res_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      wait_n = (got_n == 20) ? 3000 : (no_idle ? 0 : $urandom_range(0, 16));
      if (wait_n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        got = res_ch.valid;
        @(posedge clk);
      end while (!got);
      got_n++;
    end
  end

  initial begin
    int ni;
    int nh;
    int nc;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_INPUT_COUNT;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_HID_WEIGHT;
    req_ch.neuron = '0;
    req_ch.column = '0;
    req_ch.value = '0;
    req_ch.last = 1'b0;
    no_idle = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: small net, saturating hidden value, ReLU clip, ties, ignored requests
    write_cfg(2, 2, 3);
    load_net(2, 2, 3);
    send_req(CMD_HID_BIAS, 0, 0, 16'sh7FFF, 1'b1);
    send_req(CMD_HID_WEIGHT, 0, 0, 16'sh7FFF, 1'b0);
    send_req(CMD_HID_WEIGHT, 0, 1, 16'sh7FFF, 1'b0);
    send_req(CMD_HID_BIAS, 1, 0, 16'sh8000, 1'b0);
    send_req(CMD_HID_WEIGHT, 127, 1023, 16'sh8000, 1'b1);
    send_req(CMD_CLS_WEIGHT, 127, 1023, 16'sh7FFF, 1'b1);
    send_req(CMD_CLS_BIAS, 100, 0, 16'sh7FFF, 1'b0);
    send_req(3'd5, 127, 1023, 16'shFFFF, 1'b1);
    send_req(3'd6, 0, 0, 16'sh0000, 1'b1);
    send_req(3'd7, 64, 512, 16'sh5555, 1'b1);
    send_req(CMD_PIXEL, 0, 0, 16'shFFFF, 1'b0);
    send_req(CMD_PIXEL, 127, 1023, 16'sh00AA, 1'b0);
    send_req(CMD_PIXEL, 0, 1, 16'sh7F80, 1'b1);
    for (int c = 0; c < 3; c++) begin
      send_req(CMD_CLS_BIAS, c, 0, 16'sh0100, 1'b0);
      for (int h = 0; h < 2; h++) send_req(CMD_CLS_WEIGHT, c, h, 16'sh0000, 1'b0);
    end
    send_req(CMD_PIXEL, 0, 0, 16'sh0000, 1'b1);

    // Count extremes: zero, widest and past the top of the hidden and class counts
    write_cfg(0, 0, 0);
    load_net(1, 1, 1);
    write_cfg(1, 255, 1);
    load_net(1, 128, 1);
    write_cfg(1, 1, 31);
    load_net(1, 1, 16);
    write_cfg(1, 128, 1);
    send_req(CMD_PIXEL, 0, 0, coef_t'($urandom), 1'b1);
    send_req(CMD_PIXEL, 0, 0, 16'sh00FF, 1'b1);
    write_cfg(1, 1, 16);
    send_req(CMD_PIXEL, 0, 0, coef_t'($urandom), 1'b1);

    // Random phases on small nets
    for (int p = 0; p < 6; p++) begin
      ni = $urandom_range(1, 12);
      nh = $urandom_range(1, 6);
      nc = $urandom_range(1, 16);
      write_cfg(ni, nh, nc);
      load_net(eff(ni, 1024), eff(nh, 128), eff(nc, 16));
      run_traffic(85, ni, nh, nc);
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("mlp_relu_inference_argmax_unit regression: pass");
    end else begin
      $display("mlp_relu_inference_argmax_unit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/mri_pkg.sv
hdl/mri_if.sv
hdl/mlp_relu_inference_argmax_unit.sv
test/mri_checker.sv
test/tb_mlp_relu_inference_argmax_unit.sv
